FILE: rtl/core/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kind codes, character codes, field widths and the records that pass
// between the scanner front end, the command queue and the token emitter.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Field widths of one result item
  localparam int unsigned KIND_W   = 5;
  localparam int unsigned LINE_W   = 24;
  localparam int unsigned COL_W    = 16;
  localparam int unsigned MANT_W   = 48;
  localparam int unsigned FRAC_W   = 6;
  localparam int unsigned CHUNK_W  = 64;
  localparam int unsigned NBYTES_W = 4;
  // Token length as carried in a command; covers the largest length limit
  localparam int unsigned LEN_W    = 8;

  // Saturation limits
  localparam logic [LINE_W-1:0] LINE_TOP = '1;
  localparam logic [COL_W-1:0]  COL_TOP  = '1;
  localparam logic [MANT_W-1:0] MANT_TOP = '1;
  localparam logic [FRAC_W-1:0] FRAC_TOP = '1;

  // Command queue between front end and emitter
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  // Token kinds
  localparam logic [KIND_W-1:0] K_NUM    = 5'd0;
  localparam logic [KIND_W-1:0] K_IDENT  = 5'd1;
  localparam logic [KIND_W-1:0] K_LET    = 5'd2;
  localparam logic [KIND_W-1:0] K_PLUS   = 5'd3;
  localparam logic [KIND_W-1:0] K_MINUS  = 5'd4;
  localparam logic [KIND_W-1:0] K_MUL    = 5'd5;
  localparam logic [KIND_W-1:0] K_DIV    = 5'd6;
  localparam logic [KIND_W-1:0] K_ASSIGN = 5'd7;
  localparam logic [KIND_W-1:0] K_EQ     = 5'd8;
  localparam logic [KIND_W-1:0] K_GT     = 5'd9;
  localparam logic [KIND_W-1:0] K_GE     = 5'd10;
  localparam logic [KIND_W-1:0] K_LT     = 5'd11;
  localparam logic [KIND_W-1:0] K_LE     = 5'd12;
  localparam logic [KIND_W-1:0] K_NE     = 5'd13;
  localparam logic [KIND_W-1:0] K_LPAREN = 5'd14;
  localparam logic [KIND_W-1:0] K_RPAREN = 5'd15;
  localparam logic [KIND_W-1:0] K_SEMI   = 5'd16;
  localparam logic [KIND_W-1:0] K_ERROR  = 5'd17;
  localparam logic [KIND_W-1:0] K_EOF    = 5'd18;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  // One finished token as handed from front end to emitter
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [MANT_W-1:0] mant;
    logic [FRAC_W-1:0] frac;
    logic [LEN_W-1:0]  len;        // identifier length
    logic              bank;       // text buffer bank of the identifier
    logic              item_last;  // last token caused by its input item
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [LINE_W-1:0]   line;
    logic [COL_W-1:0]    col;
    logic [MANT_W-1:0]   mant;
    logic [FRAC_W-1:0]   frac;
    logic [CHUNK_W-1:0]  chunk;
    logic [NBYTES_W-1:0] nbytes;
    logic                tok_end;
    logic                in_done;
  } res_t;

  // Text buffer bank handed back once its identifier is fully sent
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

FILE: rtl/core/stt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_front: scanner front end
// Takes one source byte per item, tracks position, builds numbers, writes
// identifier bytes to the text buffer and queues finished tokens in order.
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; #(
  parameter int unsigned MAX_TOKEN_CHARS = 63
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // source items
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_end_i,
  // token commands to the queue
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_full_i,
  // text buffer write port
  output logic             wr_en_o,
  output logic             wr_bank_o,
  output logic [LEN_W-1:0] wr_pos_o,
  output logic [7:0]       wr_byte_o,
  // bank handed back by the emitter
  input  rel_t             rel_i
);

  localparam int unsigned TLEN_W = $clog2(MAX_TOKEN_CHARS + 1);
  localparam logic [TLEN_W-1:0] MAX_LEN = TLEN_W'(MAX_TOKEN_CHARS);

  // scan modes
  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_INT   = 3'd1;
  localparam logic [2:0] M_FRAC  = 3'd2;
  localparam logic [2:0] M_IDENT = 3'd3;
  localparam logic [2:0] M_EQ    = 3'd4;
  localparam logic [2:0] M_GT    = 3'd5;
  localparam logic [2:0] M_LT    = 3'd6;
  localparam logic [2:0] M_NOT   = 3'd7;

  logic [2:0]        mode_q, mode_d;
  logic [LINE_W-1:0] cur_line_q, cur_line_d, st_line_q, st_line_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d, st_col_q, st_col_d;
  logic [MANT_W-1:0] digit_q, digit_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [TLEN_W-1:0] len_q, len_d;
  logic              let_q, let_d;
  logic              bank_q, bank_d;
  logic [1:0]        busy_q, busy_d;
  logic [2:0]        pend_q, pend_d;
  cmd_t              slot_q [3];

  logic       acc;
  logic [7:0] ch;
  logic       is_dig, is_alpha, is_idc, is_spc, room;
  logic       fl, no_err, scan, combo, eof, wr_go, wr_new, set_busy;
  logic       va, vb, vc;
  cmd_t       a_cmd, b_cmd, c_cmd;
  logic [MANT_W+3:0] mul10;
  logic [MANT_W-1:0] digit_sat;
  logic [COL_W:0]    dsum;
  logic [COL_W-1:0]  dcol;
  logic [2:0]        pop_sel, left;
  logic              push, bank_ok;

  assign acc = in_valid_i && in_ready_o;
  assign ch  = in_byte_i;

  // character classes
  assign is_dig   = ch inside {[CH_0:CH_9]};
  assign is_alpha = (ch inside {[CH_LA:CH_LZ]}) || (ch inside {[CH_UA:CH_UZ]});
  assign is_idc   = is_alpha || is_dig || (ch == CH_US);
  assign is_spc   = (ch == CH_SP) || (ch inside {[CH_TAB:CH_CR]});
  assign room     = len_q < MAX_LEN;

  // mantissa times ten plus digit, saturating
  assign mul10     = {digit_q, 3'b000} + {2'b00, digit_q, 1'b0} + (MANT_W+4)'(ch[3:0]);
  assign digit_sat = (mul10 > {4'b0000, MANT_TOP}) ? MANT_TOP : mul10[MANT_W-1:0];

  // column of a dangling dot
  assign dsum = {1'b0, st_col_q} + (COL_W+1)'(len_q) - (COL_W+1)'(1);
  assign dcol = (dsum > {1'b0, COL_TOP}) ? COL_TOP : dsum[COL_W-1:0];

  // scanner next state and token commands of one item
  always_comb begin
    mode_d     = mode_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    st_line_d  = st_line_q;
    st_col_d   = st_col_q;
    digit_d    = digit_q;
    frac_d     = frac_q;
    len_d      = len_q;
    let_d      = let_q;
    bank_d     = bank_q;
    fl         = 1'b0;
    no_err     = 1'b0;
    scan       = 1'b0;
    combo      = 1'b0;
    eof        = 1'b0;
    wr_go      = 1'b0;
    wr_new     = 1'b0;
    set_busy   = 1'b0;
    va         = 1'b0;
    vb         = 1'b0;
    vc         = 1'b0;
    a_cmd      = '0;
    b_cmd      = '0;
    c_cmd      = '0;

    // continue the open token or decide to end it
    if (in_end_i) begin
      fl  = 1'b1;
      eof = 1'b1;
    end else begin
      case (mode_q)
        M_INT: begin
          if (is_dig && room) begin
            digit_d = digit_sat;
            len_d   = len_q + TLEN_W'(1);
          end else if (ch == CH_DOT && room) begin
            len_d  = len_q + TLEN_W'(1);
            frac_d = '0;
            mode_d = M_FRAC;
          end else begin
            fl   = 1'b1;
            scan = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_dig && room) begin
            digit_d = digit_sat;
            len_d   = len_q + TLEN_W'(1);
            if (frac_q != FRAC_TOP) frac_d = frac_q + FRAC_W'(1);
          end else if (is_dig && frac_q == '0) begin
            // full after the dot: number without fraction, digit starts anew
            fl     = 1'b1;
            no_err = 1'b1;
            scan   = 1'b1;
          end else begin
            fl   = 1'b1;
            scan = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_idc && room) begin
            wr_go = 1'b1;
            len_d = len_q + TLEN_W'(1);
            if (len_q == TLEN_W'(1)) begin
              let_d = let_q && (ch == CH_E);
            end else if (len_q == TLEN_W'(2)) begin
              let_d = let_q && (ch == CH_T);
            end else begin
              let_d = 1'b0;
            end
          end else begin
            fl   = 1'b1;
            scan = 1'b1;
          end
        end
        M_EQ, M_GT, M_LT, M_NOT: begin
          if (ch == CH_EQ) begin
            combo  = 1'b1;
            mode_d = M_IDLE;
          end else begin
            fl   = 1'b1;
            scan = 1'b1;
          end
        end
        default: scan = 1'b1;
      endcase
    end

    // flush the open token
    if (fl) begin
      mode_d     = M_IDLE;
      a_cmd.line = st_line_q;
      a_cmd.col  = st_col_q;
      case (mode_q)
        M_INT, M_FRAC: begin
          va         = 1'b1;
          a_cmd.kind = K_NUM;
          a_cmd.mant = digit_q;
          a_cmd.frac = (mode_q == M_FRAC) ? frac_q : '0;
        end
        M_IDENT: begin
          va = 1'b1;
          if (let_q && len_q == TLEN_W'(3)) begin
            a_cmd.kind = K_LET;
          end else begin
            a_cmd.kind = K_IDENT;
            a_cmd.len  = LEN_W'(len_q);
            a_cmd.bank = bank_q;
            set_busy   = 1'b1;
          end
        end
        M_EQ: begin
          va         = 1'b1;
          a_cmd.kind = K_ASSIGN;
        end
        M_GT: begin
          va         = 1'b1;
          a_cmd.kind = K_GT;
        end
        M_LT: begin
          va         = 1'b1;
          a_cmd.kind = K_LT;
        end
        M_NOT: begin
          va         = 1'b1;
          a_cmd.kind = K_ERROR;
        end
        default: ;
      endcase
      // dot with no digit after it
      if (mode_q == M_FRAC && frac_q == '0 && !no_err) begin
        vb         = 1'b1;
        b_cmd.kind = K_ERROR;
        b_cmd.line = st_line_q;
        b_cmd.col  = dcol;
      end
    end

    // start of a new token
    if (scan && !is_spc) begin
      st_line_d = cur_line_q;
      st_col_d  = cur_col_q;
      if (is_dig) begin
        mode_d  = M_INT;
        digit_d = MANT_W'(ch[3:0]);
        frac_d  = '0;
        len_d   = TLEN_W'(1);
      end else if (is_alpha || ch == CH_US) begin
        mode_d = M_IDENT;
        bank_d = ~bank_q;
        wr_go  = 1'b1;
        wr_new = 1'b1;
        len_d  = TLEN_W'(1);
        let_d  = (ch == CH_L);
      end else begin
        case (ch)
          CH_PLUS: begin
            vc         = 1'b1;
            c_cmd.kind = K_PLUS;
          end
          CH_MINUS: begin
            vc         = 1'b1;
            c_cmd.kind = K_MINUS;
          end
          CH_STAR: begin
            vc         = 1'b1;
            c_cmd.kind = K_MUL;
          end
          CH_SLASH: begin
            vc         = 1'b1;
            c_cmd.kind = K_DIV;
          end
          CH_LPAR: begin
            vc         = 1'b1;
            c_cmd.kind = K_LPAREN;
          end
          CH_RPAR: begin
            vc         = 1'b1;
            c_cmd.kind = K_RPAREN;
          end
          CH_SEMI: begin
            vc         = 1'b1;
            c_cmd.kind = K_SEMI;
          end
          CH_EQ:   mode_d = M_EQ;
          CH_GT:   mode_d = M_GT;
          CH_LT:   mode_d = M_LT;
          CH_BANG: mode_d = M_NOT;
          default: begin
            vc         = 1'b1;
            c_cmd.kind = K_ERROR;
          end
        endcase
      end
    end

    // two-character operators
    if (combo) begin
      vc = 1'b1;
      case (mode_q)
        M_EQ:    c_cmd.kind = K_EQ;
        M_GT:    c_cmd.kind = K_GE;
        M_LT:    c_cmd.kind = K_LE;
        default: c_cmd.kind = K_NE;
      endcase
    end
    if (eof) begin
      vc         = 1'b1;
      c_cmd.kind = K_EOF;
    end
    c_cmd.line = combo ? st_line_q : cur_line_q;
    c_cmd.col  = combo ? st_col_q : cur_col_q;

    a_cmd.item_last = va && !vb && !vc;
    b_cmd.item_last = vb && !vc;
    c_cmd.item_last = vc;

    // position after the byte
    if (!in_end_i) begin
      if (ch == CH_LF) begin
        if (cur_line_q != LINE_TOP) cur_line_d = cur_line_q + LINE_W'(1);
        cur_col_d = COL_W'(1);
      end else if (cur_col_q != COL_TOP) begin
        cur_col_d = cur_col_q + COL_W'(1);
      end
    end
  end

  // text buffer write
  assign wr_en_o   = acc && wr_go;
  assign wr_bank_o = wr_new ? ~bank_q : bank_q;
  assign wr_pos_o  = wr_new ? '0 : LEN_W'(len_q);
  assign wr_byte_o = ch;

  // hand pending commands to the queue, oldest first
  always_comb begin
    if (pend_q[0]) begin
      pop_sel = 3'b001;
      cmd_o   = slot_q[0];
    end else if (pend_q[1]) begin
      pop_sel = 3'b010;
      cmd_o   = slot_q[1];
    end else begin
      pop_sel = {pend_q[2], 2'b00};
      cmd_o   = slot_q[2];
    end
  end
  assign cmd_valid_o = |pend_q;
  assign push        = cmd_valid_o && !cmd_full_i;
  assign left        = pend_q & ~(push ? pop_sel : 3'b000);

  // a new identifier needs the other bank free; a running one needs nothing
  assign bank_ok    = !busy_q[~bank_q] || (mode_q == M_IDENT && room);
  assign in_ready_o = (left == 3'b000) && bank_ok;

  always_comb begin
    pend_d = acc ? {vc, vb, va} : left;
    busy_d = busy_q;
    if (acc && set_busy) busy_d[bank_q] = 1'b1;
    if (rel_i.valid)     busy_d[rel_i.bank] = 1'b0;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_IDLE;
      cur_line_q <= LINE_W'(1);
      cur_col_q  <= COL_W'(1);
      st_line_q  <= LINE_W'(1);
      st_col_q   <= COL_W'(1);
      digit_q    <= '0;
      frac_q     <= '0;
      len_q      <= '0;
      let_q      <= 1'b0;
      bank_q     <= 1'b0;
      busy_q     <= '0;
      pend_q     <= '0;
    end else begin
      if (acc) begin
        mode_q     <= mode_d;
        cur_line_q <= cur_line_d;
        cur_col_q  <= cur_col_d;
        st_line_q  <= st_line_d;
        st_col_q   <= st_col_d;
        digit_q    <= digit_d;
        frac_q     <= frac_d;
        len_q      <= len_d;
        let_q      <= let_d;
        bank_q     <= bank_d;
      end
      busy_q <= busy_d;
      pend_q <= pend_d;
    end
  end

  // command slots
  always_ff @(posedge clk_i) begin
    if (acc) begin
      slot_q[0] <= a_cmd;
      slot_q[1] <= b_cmd;
      slot_q[2] <= c_cmd;
    end
  end

  // text bytes never land in a bank that the emitter still reads
  a_wr_free_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> !busy_q[wr_bank_o])
    else $error("text write into a bank still being sent");

  // end of text always closes scanning and queues eof
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_end_i |=> pend_q[2] && mode_q == M_IDLE)
    else $error("end of text did not close the scan");

endmodule

FILE: rtl/core/stt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_queue: token command queue
// Short first-in first-out store that decouples the scanner from the emitter.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;
  cmd_t              mem_q [QUEUE_DEPTH];
  logic              do_push;

  assign full_o  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + QPTR_W'(1);
      if (pop_i)   rptr_q <= rptr_q + QPTR_W'(1);
      if (do_push && !pop_i) cnt_q <= cnt_q + (QPTR_W+1)'(1);
      else if (pop_i && !do_push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
    end
  end

  // entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_cmd_i;
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue popped while empty");

endmodule

FILE: rtl/core/stt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_back: token emitter
// Turns queued token commands into result items; identifiers are read from a
// two-bank text buffer, sent in 8-byte chunks, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module stt_back import stt_pkg::*; #(
  parameter int unsigned MAX_TOKEN_CHARS = 63
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // head of the command queue
  input  logic             q_valid_i,
  input  cmd_t             q_head_i,
  output logic             q_pop_o,
  // text buffer write port
  input  logic             wr_en_i,
  input  logic             wr_bank_i,
  input  logic [LEN_W-1:0] wr_pos_i,
  input  logic [7:0]       wr_byte_i,
  // bank released after its last chunk
  output rel_t             rel_o,
  // result items
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output res_t             out_o
);

  localparam int unsigned ROWS      = (MAX_TOKEN_CHARS + 7) / 8;
  localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned MEM_DEPTH = 2 * (2 ** ROW_W);

  localparam logic BS_IDLE  = 1'b0;
  localparam logic BS_CHUNK = 1'b1;

  logic               state_q, state_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [CHUNK_W-1:0] mem_q [MEM_DEPTH];
  logic [CHUNK_W-1:0] rd_q, masked;
  logic               rd_en;
  logic [ROW_W:0]     rd_addr;
  logic               out_v_q, out_free, load;
  res_t               out_q, res_d;
  logic [LEN_W-1:0]   rem;
  logic               last;
  logic [NBYTES_W-1:0] nb;

  // text buffer: byte writes, registered row reads
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[{wr_bank_i, wr_pos_i[3 +: ROW_W]}][{wr_pos_i[2:0], 3'b000} +: 8] <= wr_byte_i;
    end
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // bytes left in the current chunk
  assign rem  = q_head_i.len - (LEN_W'(row_q) << 3);
  assign last = rem <= LEN_W'(8);
  assign nb   = last ? rem[NBYTES_W-1:0] : NBYTES_W'(8);

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      masked[j*8 +: 8] = (NBYTES_W'(j) < nb) ? rd_q[j*8 +: 8] : 8'h00;
    end
  end

  assign out_free = !out_v_q || out_ready_i;

  // emitter sequencing
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    rd_en   = 1'b0;
    rd_addr = {q_head_i.bank, row_q};
    q_pop_o = 1'b0;
    rel_o   = '0;
    load    = 1'b0;
    res_d   = '0;
    res_d.line = q_head_i.line;
    res_d.col  = q_head_i.col;
    case (state_q)
      BS_IDLE: begin
        if (q_valid_i) begin
          if (q_head_i.kind != K_IDENT) begin
            if (out_free) begin
              load          = 1'b1;
              q_pop_o       = 1'b1;
              res_d.kind    = q_head_i.kind;
              res_d.mant    = q_head_i.mant;
              res_d.frac    = q_head_i.frac;
              res_d.tok_end = 1'b1;
              res_d.in_done = q_head_i.item_last;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = {q_head_i.bank, {ROW_W{1'b0}}};
            row_d   = '0;
            state_d = BS_CHUNK;
          end
        end
      end
      BS_CHUNK: begin
        if (out_free) begin
          load          = 1'b1;
          res_d.kind    = K_IDENT;
          res_d.chunk   = masked;
          res_d.nbytes  = nb;
          res_d.tok_end = last;
          res_d.in_done = last && q_head_i.item_last;
          if (last) begin
            q_pop_o    = 1'b1;
            rel_o.valid = 1'b1;
            rel_o.bank  = q_head_i.bank;
            state_d    = BS_IDLE;
          end else begin
            row_d   = row_q + ROW_W'(1);
            rd_en   = 1'b1;
            rd_addr = {q_head_i.bank, row_q + ROW_W'(1)};
          end
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      row_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      if (load)             out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) out_q <= res_d;
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // an identifier stays at the queue head for all its chunks
  a_chunk_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BS_CHUNK |-> q_valid_i && q_head_i.kind == K_IDENT)
    else $error("chunking without an identifier at the queue head");

  // the row being sent lies inside the identifier
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BS_CHUNK |-> (LEN_W'(row_q) << 3) < q_head_i.len)
    else $error("chunk row beyond identifier length");

endmodule

FILE: rtl/core/source_text_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer: byte-stream lexer
// Scans source bytes into number, identifier, keyword and operator tokens
// with line and column of each token start.
// ----------------------------------------------------------------------------
//  port group  | dir | tdata                          | tuser | tlast
//  s_axis      | in  | byte_in[7:0]                   | -     | end_of_text
//  m_axis      | out | line, column, mantissa, frac,  | kind  | token_end
//              |     | text chunk, chunk bytes, done  |       |
//
// An item that yields at most one token is taken every cycle unless the queue
// or a bank holds it; one that yields k tokens holds the input while the front
// end queues them. An identifier of n bytes leaves as ceil(n/8) items, one per
// cycle unless the output stalls, after a registered text buffer read. Outside
// an identifier, or at its length limit, an item waits while the identifier
// before the previous one is still being sent, since the buffer has two banks.
// Reset is asynchronous and active low; the text buffer needs no clearing.
// Output stalls back up through a 4-entry command queue to the input.
// ----------------------------------------------------------------------------
module source_text_tokenizer import stt_pkg::*; #(
  parameter int unsigned MAX_TOKEN_CHARS = 63
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] byte_in
  input  logic         s_axis_tlast,  // end_of_text
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [23:0] tok_line, [39:24] tok_column, [87:40] mantissa, [93:88] frac_digits,
  // [157:94] text_chunk, [161:158] chunk_bytes, [162] input_done, [167:163] zero
  output logic [167:0] m_axis_tdata,
  output logic [4:0]   m_axis_tuser,  // kind
  output logic         m_axis_tlast   // token_end
);

  logic             cmd_valid, q_full, q_valid, q_pop;
  cmd_t             cmd, q_head;
  logic             wr_en, wr_bank;
  logic [LEN_W-1:0] wr_pos;
  logic [7:0]       wr_byte;
  rel_t             rel;
  res_t             res;

  stt_front #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_full_i  (q_full),
    .wr_en_o     (wr_en),
    .wr_bank_o   (wr_bank),
    .wr_pos_o    (wr_pos),
    .wr_byte_o   (wr_byte),
    .rel_i       (rel)
  );

  stt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_valid),
    .push_cmd_i (cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  stt_back #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .wr_en_i     (wr_en),
    .wr_bank_i   (wr_bank),
    .wr_pos_i    (wr_pos),
    .wr_byte_i   (wr_byte),
    .rel_o       (rel),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // result packing
  assign m_axis_tdata = {5'b00000, res.in_done, res.nbytes, res.chunk, res.frac,
                         res.mant, res.col, res.line};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.tok_end;

endmodule
